// ===== rtl/spr_pkg.sv =====
// shared types and constants for the shortest path route table
// command and status structs between the sequencer and the datapath
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int ADJ_ROWS      = 16;
  localparam int ADJ_AW        = 4;
  localparam int NODE_W        = 4;
  localparam int DIST_W        = 5;
  localparam int QC_W          = 5;
  localparam int CMP_W         = 7;

  localparam logic [DIST_W-1:0] UNREACH  = 5'd31;
  localparam logic [QC_W-1:0]   QC_RESET = 5'd16;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_COMPUTE = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_QRD,
    OP_LOUT,
    OP_QOUT,
    OP_COUT,
    OP_INIT_START,
    OP_INIT_RD,
    OP_INIT_WR,
    OP_FW_ROW,
    OP_FW_LAT,
    OP_FW_STEP,
    OP_RT_RD,
    OP_RT_CHK,
    OP_RT_K,
    OP_RT_K2,
    OP_CK_RD,
    OP_CK_EV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic i_last;
    logic j_last;
    logic k_last;
    logic init_last;
    logic edge_ij;
    logic k_hit;
    logic out_space;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/spr_ctrl.sv =====
// sequencer for the route table: input beats, table build phases, result beats
// drives datapath commands from datapath status, uses spr_pkg
`timescale 1ns / 1ps
`default_nettype none

module spr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  output spr_pkg::cmd_t    cmd,
  input  spr_pkg::sts_t    sts
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_LOUT    = 15'b000000000000010,
    S_QOUT    = 15'b000000000000100,
    S_INIT_RD = 15'b000000000001000,
    S_INIT_WR = 15'b000000000010000,
    S_FW_ROW  = 15'b000000000100000,
    S_FW_LAT  = 15'b000000001000000,
    S_FW_STEP = 15'b000000010000000,
    S_RT_RD   = 15'b000000100000000,
    S_RT_CHK  = 15'b000001000000000,
    S_RT_K    = 15'b000010000000000,
    S_RT_K2   = 15'b000100000000000,
    S_CK_RD   = 15'b001000000000000,
    S_CK_EV   = 15'b010000000000000,
    S_COUT    = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;
  state_t rt_done_next;

  assign in_ready = (state == S_IDLE);

  // where the edge walk goes once a source pair is finished
  always_comb begin
    if (sts.i_last && sts.j_last) begin
      rt_done_next = S_CK_RD;
    end else begin
      rt_done_next = S_RT_RD;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = spr_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            spr_pkg::KIND_LOAD: begin
              cmd.op     = spr_pkg::OP_LOAD;
              state_next = S_LOUT;
            end
            spr_pkg::KIND_COMPUTE: begin
              cmd.op     = spr_pkg::OP_INIT_START;
              state_next = S_INIT_RD;
            end
            spr_pkg::KIND_QUERY: begin
              cmd.op     = spr_pkg::OP_QRD;
              state_next = S_QOUT;
            end
            default: begin
              state_next = S_LOUT;
            end
          endcase
        end
      end
      S_LOUT: begin
        if (sts.out_space) begin
          cmd.op     = spr_pkg::OP_LOUT;
          state_next = S_IDLE;
        end
      end
      S_QOUT: begin
        if (sts.out_space) begin
          cmd.op     = spr_pkg::OP_QOUT;
          state_next = S_IDLE;
        end
      end
      S_INIT_RD: begin
        cmd.op     = spr_pkg::OP_INIT_RD;
        state_next = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd.op = spr_pkg::OP_INIT_WR;
        if (!sts.init_last) begin
          state_next = S_INIT_RD;
        end else if (sts.n_zero) begin
          state_next = S_COUT;
        end else begin
          state_next = S_FW_ROW;
        end
      end
      S_FW_ROW: begin
        cmd.op     = spr_pkg::OP_FW_ROW;
        state_next = S_FW_LAT;
      end
      S_FW_LAT: begin
        cmd.op     = spr_pkg::OP_FW_LAT;
        state_next = S_FW_STEP;
      end
      S_FW_STEP: begin
        cmd.op = spr_pkg::OP_FW_STEP;
        if (sts.j_last) begin
          if (sts.i_last && sts.k_last) begin
            state_next = S_RT_RD;
          end else begin
            state_next = S_FW_ROW;
          end
        end
      end
      S_RT_RD: begin
        cmd.op     = spr_pkg::OP_RT_RD;
        state_next = S_RT_CHK;
      end
      S_RT_CHK: begin
        cmd.op = spr_pkg::OP_RT_CHK;
        if (sts.edge_ij) begin
          state_next = S_RT_K;
        end else begin
          state_next = rt_done_next;
        end
      end
      S_RT_K: begin
        cmd.op = spr_pkg::OP_RT_K;
        if (sts.k_hit) begin
          state_next = S_RT_K2;
        end else if (sts.k_last) begin
          state_next = rt_done_next;
        end
      end
      S_RT_K2: begin
        cmd.op = spr_pkg::OP_RT_K2;
        if (sts.k_last) begin
          state_next = rt_done_next;
        end else begin
          state_next = S_RT_K;
        end
      end
      S_CK_RD: begin
        cmd.op     = spr_pkg::OP_CK_RD;
        state_next = S_CK_EV;
      end
      S_CK_EV: begin
        cmd.op = spr_pkg::OP_CK_EV;
        if (sts.i_last && sts.j_last) begin
          state_next = S_COUT;
        end else begin
          state_next = S_CK_RD;
        end
      end
      S_COUT: begin
        if (sts.out_space) begin
          cmd.op     = spr_pkg::OP_COUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spr_datapath.sv =====
// datapath of the route table: adjacency rows, distance and route memories,
// loop counters, relaxation adder, qubit_count register and result register
// takes commands from spr_ctrl, uses spr_pkg
`timescale 1ns / 1ps
`default_nettype none

module spr_datapath #(
  parameter int MAX_NODES = spr_pkg::MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  spr_pkg::cmd_t                cmd,
  output spr_pkg::sts_t                sts,
  input  logic [spr_pkg::NODE_W-1:0]   row_node,
  input  logic [spr_pkg::NODE_W-1:0]   col_node,
  input  logic [spr_pkg::ADJ_ROWS-1:0] adjacency_bits,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spr_pkg::QC_W-1:0]     cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spr_pkg::NODE_W-1:0]   next_hop,
  output logic                         route_valid,
  output logic [spr_pkg::DIST_W-1:0]   distance,
  output logic                         all_connected
);

  localparam int NW     = $clog2(MAX_NODES);
  localparam int AW     = 2 * NW;
  localparam int DEPTH  = 1 << AW;
  localparam int RWW    = NW + 1;
  localparam int CMP_W  = spr_pkg::CMP_W;
  localparam int DW     = spr_pkg::DIST_W;
  localparam int ROWS   = spr_pkg::ADJ_ROWS;
  localparam int ADJ_AW = spr_pkg::ADJ_AW;
  localparam logic [NW-1:0] NODE_LAST = NW'(MAX_NODES - 1);

  // tables: distance, and route word {ok, next hop}
  logic [DW-1:0]  dist_mem  [DEPTH];
  logic [RWW-1:0] route_mem [DEPTH];
  logic [ROWS-1:0] adj_mem  [ROWS];
  logic [ROWS-1:0] adj_vld;

  logic [spr_pkg::QC_W-1:0] qubit_count;

  logic [NW-1:0] i, j, k;
  logic [NW-1:0] i_adv, j_adv;
  logic          conn;
  logic          q_oor;
  logic [DW-1:0] dik;
  logic [RWW-1:0] rik;

  logic [CMP_W-1:0] n_use, nm1, i_w, j_w, k_w;
  logic i_adj_ok, j_adj_ok, k_adj_ok;

  logic          rd_a_en, rd_b_en, adj_rd_en;
  logic [AW-1:0] addr_a, addr_b;
  logic [DW-1:0]  dist_a_q, dist_b_q;
  logic [RWW-1:0] route_a_q;
  logic [ROWS-1:0] adj_a_q, adj_b_q;

  logic           dist_we, route_we;
  logic [AW-1:0]  dist_wa, route_wa;
  logic [DW-1:0]  dist_wd;
  logic [RWW-1:0] route_wd;

  logic          link;
  logic [DW:0]   sum;
  logic [DW-1:0] sat;
  logic          relax;
  logic          load_ok;

  assign cfg_ready = 1'b1;

  // node count in use and loop bounds
  always_comb begin
    if (CMP_W'(qubit_count) > CMP_W'(MAX_NODES)) begin
      n_use = CMP_W'(MAX_NODES);
    end else begin
      n_use = CMP_W'(qubit_count);
    end
    nm1      = n_use - 1'b1;
    i_w      = CMP_W'(i);
    j_w      = CMP_W'(j);
    k_w      = CMP_W'(k);
    i_adj_ok = i_w < CMP_W'(ROWS);
    j_adj_ok = j_w < CMP_W'(ROWS);
    k_adj_ok = k_w < CMP_W'(ROWS);
    load_ok  = CMP_W'(row_node) < CMP_W'(MAX_NODES);
  end

  assign sts.n_zero    = (n_use == '0);
  assign sts.i_last    = (i_w == nm1);
  assign sts.j_last    = (j_w == nm1);
  assign sts.k_last    = (k_w == nm1);
  assign sts.init_last = (i == NODE_LAST) && (j == NODE_LAST);
  assign sts.edge_ij   = (i != j) && i_adj_ok && j_adj_ok && adj_a_q[ADJ_AW'(j)];
  assign sts.k_hit     = (k != j) && k_adj_ok && adj_b_q[ADJ_AW'(k)];
  assign sts.out_space = !out_valid || out_ready;

  // pair walk over the nodes in use
  always_comb begin
    if (sts.j_last) begin
      j_adv = '0;
      i_adv = sts.i_last ? '0 : i + 1'b1;
    end else begin
      j_adv = j + 1'b1;
      i_adv = i;
    end
  end

  // seed entry and relaxation
  always_comb begin
    link  = (i_w < n_use) && (j_w < n_use) &&
            ((i == j) ||
             (i_adj_ok && j_adj_ok && adj_a_q[ADJ_AW'(j)]) ||
             (i_adj_ok && j_adj_ok && adj_b_q[ADJ_AW'(i)]));
    sum   = {1'b0, dik} + {1'b0, dist_b_q};
    sat   = (sum > (DW + 1)'(spr_pkg::UNREACH)) ? spr_pkg::UNREACH : sum[DW-1:0];
    relax = dist_a_q > sat;
  end

  // memory port steering
  always_comb begin
    rd_a_en   = 1'b0;
    rd_b_en   = 1'b0;
    adj_rd_en = 1'b0;
    addr_a    = {i, j};
    addr_b    = {k, j};
    dist_we   = 1'b0;
    route_we  = 1'b0;
    dist_wa   = {i, j};
    route_wa  = {i, j};
    dist_wd   = sat;
    route_wd  = rik;
    unique case (cmd.op)
      spr_pkg::OP_QRD: begin
        rd_a_en = 1'b1;
        addr_a  = {NW'(row_node), NW'(col_node)};
      end
      spr_pkg::OP_INIT_RD, spr_pkg::OP_RT_RD: begin
        adj_rd_en = 1'b1;
      end
      spr_pkg::OP_INIT_WR: begin
        dist_we  = 1'b1;
        route_we = 1'b1;
        dist_wd  = link ? DW'(1) : spr_pkg::UNREACH;
        route_wd = link ? {1'b1, j} : '0;
      end
      spr_pkg::OP_FW_ROW: begin
        rd_a_en = 1'b1;
        addr_a  = {i, k};
      end
      spr_pkg::OP_FW_LAT: begin
        rd_a_en = 1'b1;
        rd_b_en = 1'b1;
        addr_a  = {i, NW'(0)};
        addr_b  = {k, NW'(0)};
      end
      spr_pkg::OP_FW_STEP: begin
        dist_we  = relax;
        route_we = relax;
        rd_a_en  = !sts.j_last;
        rd_b_en  = !sts.j_last;
        addr_a   = {i, j + 1'b1};
        addr_b   = {k, j + 1'b1};
      end
      spr_pkg::OP_RT_K: begin
        route_we = sts.k_hit;
        route_wa = {i, k};
        route_wd = {1'b1, j};
      end
      spr_pkg::OP_RT_K2: begin
        route_we = 1'b1;
        route_wa = {k, i};
        route_wd = {1'b1, j};
      end
      spr_pkg::OP_CK_RD: begin
        rd_a_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    if (route_we) begin
      route_mem[route_wa] <= route_wd;
    end
    if (rd_a_en) begin
      dist_a_q  <= dist_mem[addr_a];
      route_a_q <= route_mem[addr_a];
    end
    if (rd_b_en) begin
      dist_b_q <= dist_mem[addr_b];
    end
  end

  // adjacency rows, unwritten rows read as zero
  always_ff @(posedge clk) begin
    if (cmd.op == spr_pkg::OP_LOAD && load_ok) begin
      adj_mem[row_node] <= adjacency_bits;
    end
    if (adj_rd_en) begin
      adj_a_q <= adj_vld[ADJ_AW'(i)] ? adj_mem[ADJ_AW'(i)] : '0;
      adj_b_q <= adj_vld[ADJ_AW'(j)] ? adj_mem[ADJ_AW'(j)] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_vld     <= '0;
      qubit_count <= spr_pkg::QC_RESET;
    end else begin
      if (cmd.op == spr_pkg::OP_LOAD && load_ok) begin
        adj_vld[row_node] <= 1'b1;
      end
      if (cfg_valid) begin
        qubit_count <= cfg_data;
      end
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      spr_pkg::OP_QRD: begin
        q_oor <= (CMP_W'(row_node) >= n_use) || (CMP_W'(col_node) >= n_use);
      end
      spr_pkg::OP_INIT_START: begin
        i    <= '0;
        j    <= '0;
        k    <= '0;
        conn <= 1'b1;
      end
      spr_pkg::OP_INIT_WR: begin
        if (j == NODE_LAST) begin
          j <= '0;
          i <= (i == NODE_LAST) ? '0 : i + 1'b1;
        end else begin
          j <= j + 1'b1;
        end
      end
      spr_pkg::OP_FW_LAT: begin
        j   <= '0;
        dik <= dist_a_q;
        rik <= route_a_q;
      end
      spr_pkg::OP_FW_STEP: begin
        if (sts.j_last) begin
          j <= '0;
          if (sts.i_last) begin
            i <= '0;
            k <= sts.k_last ? '0 : k + 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end else begin
          j <= j + 1'b1;
        end
      end
      spr_pkg::OP_RT_CHK: begin
        if (sts.edge_ij) begin
          k <= '0;
        end else begin
          i <= i_adv;
          j <= j_adv;
        end
      end
      spr_pkg::OP_RT_K: begin
        if (!sts.k_hit) begin
          if (sts.k_last) begin
            k <= '0;
            i <= i_adv;
            j <= j_adv;
          end else begin
            k <= k + 1'b1;
          end
        end
      end
      spr_pkg::OP_RT_K2: begin
        if (sts.k_last) begin
          k <= '0;
          i <= i_adv;
          j <= j_adv;
        end else begin
          k <= k + 1'b1;
        end
      end
      spr_pkg::OP_CK_EV: begin
        conn <= conn & route_a_q[NW];
        i    <= i_adv;
        j    <= j_adv;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == spr_pkg::OP_LOUT || cmd.op == spr_pkg::OP_QOUT ||
                 cmd.op == spr_pkg::OP_COUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      spr_pkg::OP_LOUT: begin
        next_hop      <= '0;
        route_valid   <= 1'b0;
        distance      <= '0;
        all_connected <= 1'b0;
      end
      spr_pkg::OP_QOUT: begin
        all_connected <= 1'b0;
        if (q_oor) begin
          next_hop    <= '0;
          route_valid <= 1'b0;
          distance    <= spr_pkg::UNREACH;
        end else begin
          next_hop    <= spr_pkg::NODE_W'(route_a_q[NW-1:0]);
          route_valid <= route_a_q[NW];
          distance    <= dist_a_q;
        end
      end
      spr_pkg::OP_COUT: begin
        next_hop      <= '0;
        route_valid   <= 1'b0;
        distance      <= '0;
        all_connected <= conn;
      end
      default: begin
      end
    endcase
  end

  a_out_space: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == spr_pkg::OP_LOUT || cmd.op == spr_pkg::OP_QOUT ||
     cmd.op == spr_pkg::OP_COUT) |-> (!out_valid || out_ready))
    else $error("result beat loaded while the previous one is still held");

  a_query_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == spr_pkg::OP_QOUT && q_oor) |=>
      (distance == spr_pkg::UNREACH && !route_valid && out_valid))
    else $error("out of range query did not answer unreachable");

  a_fw_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == spr_pkg::OP_FW_STEP && !sts.j_last) |=>
      (k == $past(k) && i == $past(i)))
    else $error("pivot or source moved inside a relaxation row");

  a_conn_drop: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == spr_pkg::OP_CK_EV && !route_a_q[NW]) |=> !conn)
    else $error("invalid route entry did not clear the connectivity flag");

endmodule

`default_nettype wire

// ===== rtl/shortest_path_route_table.sv =====
// shortest path route table: a load or query beat is accepted in idle, and its result
// beat is loaded once the result register has space; compute seeds all MAX_NODES^2 pairs,
// relaxes one pair per cycle within a row on the two-read distance memory, walks each
// linked pair over the n pivots with a second route write per hit (edge walk), checks
// every pair; one item at a time; a held result beat does not stop the next input beat
// reset clears adjacency rows and sets qubit_count to 16; tables are undefined until compute
`timescale 1ns / 1ps
`default_nettype none

module shortest_path_route_table #(
  parameter int MAX_NODES = spr_pkg::MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   kind,
  input  logic [spr_pkg::NODE_W-1:0]   row_node,
  input  logic [spr_pkg::NODE_W-1:0]   col_node,
  input  logic [spr_pkg::ADJ_ROWS-1:0] adjacency_bits,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spr_pkg::QC_W-1:0]     cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spr_pkg::NODE_W-1:0]   next_hop,
  output logic                         route_valid,
  output logic [spr_pkg::DIST_W-1:0]   distance,
  output logic                         all_connected
);

  spr_pkg::cmd_t cmd;
  spr_pkg::sts_t sts;

  spr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .cmd      (cmd),
    .sts      (sts)
  );

  spr_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .row_node       (row_node),
    .col_node       (col_node),
    .adjacency_bits (adjacency_bits),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .next_hop       (next_hop),
    .route_valid    (route_valid),
    .distance       (distance),
    .all_connected  (all_connected)
  );

endmodule

`default_nettype wire
